// ===== sv/stbs_pkg.sv =====
package stbs_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int VALUE_WIDTH         = 32;
   localparam int POS_WIDTH           = 11;
   localparam int RSP_DATA_WIDTH      = 16;
   localparam int REQ_TYPE_WIDTH      = 2;
   localparam int STATUS_WIDTH        = 2;

   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_APPEND = 2'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_SEARCH = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_RESP
   } state_type;

endpackage

// ===== sv/stbs_ram.sv =====
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sorted_table_binary_search_core.sv =====
// Clear and append: response valid the next cycle after the request is taken.
// Search: one table probe per cycle through the registered RAM read port, at most
//    floor(log2(entry count)) + 1 probes (11 at 1024 entries); the response is
//    valid the cycle after the last probe.
// One request at a time: req_tready is high only while no request is in flight.
// Reset clears the sequencer and the entry count; table contents are left as is.
module sorted_table_binary_search_core
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [VALUE_WIDTH-1:0]    req_tdata,   // [31:0] data_value
   input  logic [REQ_TYPE_WIDTH-1:0] req_tuser,   // [1:0] req_type
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [10:0] position, [15:11] zero
   output logic [STATUS_WIDTH-1:0]   rsp_tuser    // [1:0] status
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int EXTW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   state_type state_ff, state_in;

   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             lo_ff, lo_in;
   logic [CW-1:0]             hi_ff, hi_in;
   logic [CW-1:0]             mid_ff, mid_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [STATUS_WIDTH-1:0]   status_ff, status_in;
   logic [POS_WIDTH-1:0]      position_ff, position_in;

   logic                      req_accept;
   logic                      table_full;
   logic                      ram_wr_en;
   logic [VALUE_WIDTH-1:0]    ram_rd_data;
   logic signed [VALUE_WIDTH-1:0] probe_value;
   logic                      probe_hit;
   logic                      probe_greater;
   logic [CW-1:0]             lo_next, hi_next;
   logic                      narrow_ok;
   logic [CW-1:0]             lo_sel, hi_sel;
   logic [CW:0]               span_sum;
   logic [CW-1:0]             mid_calc;
   logic [EXTW-1:0]           pos_ext;

   assign req_accept = req_tvalid && req_tready;
   assign table_full = (count_ff == CW'(TABLE_DEPTH));

   stbs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (mid_calc[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      probe_value   = $signed(ram_rd_data);
      probe_hit     = (probe_value == key_ff);
      probe_greater = (probe_value > key_ff);
      lo_next       = lo_ff;
      hi_next       = hi_ff;
      if (probe_greater) begin
         hi_next = mid_ff;
      end else begin
         lo_next = mid_ff + CW'(1);
      end
      narrow_ok = (lo_next < hi_next);
      if (state_ff == S_IDLE) begin
         lo_sel = '0;
         hi_sel = count_ff;
      end else begin
         lo_sel = lo_next;
         hi_sel = hi_next;
      end
      span_sum = {1'b0, lo_sel} + {1'b0, hi_sel} - (CW+1)'(1);
      mid_calc = span_sum[CW:1];
      pos_ext  = EXTW'(mid_ff) + EXTW'(1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == REQ_SEARCH && count_ff != '0) begin
                  state_in = S_PROBE;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_PROBE: begin
            if (probe_hit || !narrow_ok) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_RESP);
      ram_wr_en  = req_accept && (req_tuser == REQ_APPEND) && !table_full;
   end

   always_comb begin
      count_in    = count_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      key_in      = key_ff;
      status_in   = status_ff;
      position_in = position_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in      = $signed(req_tdata);
               lo_in       = '0;
               hi_in       = count_ff;
               mid_in      = mid_calc;
               status_in   = ST_DONE;
               position_in = '0;
               case (req_tuser)
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  REQ_APPEND: begin
                     if (table_full) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  REQ_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end
         S_PROBE: begin
            lo_in  = lo_next;
            hi_in  = hi_next;
            mid_in = mid_calc;
            if (probe_hit) begin
               status_in   = ST_DONE;
               position_in = pos_ext[POS_WIDTH-1:0];
            end else if (!narrow_ok) begin
               status_in   = ST_NOT_FOUND;
               position_in = '0;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      position_ff <= position_in;
   end

   assign rsp_tdata = RSP_DATA_WIDTH'(position_ff);
   assign rsp_tuser = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (lo_ff < hi_ff && mid_ff >= lo_ff && mid_ff < hi_ff))
      else $error("probe outside the search interval");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("not ready after response taken");

endmodule
